### sv/assert_macros.svh
// Assertion macros shared by the token mutex node RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset
`define TMN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TMN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tmn_pkg.sv
// Package for the token mutex node: event codes, node modes, result kinds,
// command and result structs. No dependencies.
`default_nettype none

package tmn_pkg;

  // Event codes as carried on the input tuser
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_REQ   = 3'd1,
    OP_WORD  = 3'd2,
    OP_ACQ   = 3'd3,
    OP_REL   = 3'd4
  } op_e;

  // Token ownership of this node
  typedef enum logic [1:0] {
    NM_IDLE    = 2'd0,
    NM_WAIT    = 2'd1,
    NM_PRESENT = 2'd2,
    NM_HELD    = 2'd3
  } node_mode_e;

  // Result kinds as driven on the output tuser
  typedef enum logic [1:0] {
    K_BCAST = 2'd0,
    K_TOKEN = 2'd1,
    K_GRANT = 2'd2,
    K_KEPT  = 2'd3
  } kind_e;

  // Execution sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_OWN,
    S_BCAST,
    S_GRANT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_KEEP,
    S_TOK_RD,
    S_TOK_OUT
  } back_state_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_ID       = 2'd0;
  localparam logic [1:0] CFG_CLIENT_COUNT = 2'd1;
  localparam logic [1:0] CFG_STARTS_TOKEN = 2'd2;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Live configuration, client count already saturated
  typedef struct packed {
    logic [5:0] own_id;
    logic [6:0] n_eff;
    logic       starts_with_token;
  } cfg_t;

  // Classified event passed from front to back
  typedef struct packed {
    op_e         op;
    logic [5:0]  id;
    logic [31:0] value;
    logic        store;
    logic        last;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    kind_e       kind;
    logic [5:0]  peer_id;
    logic [31:0] time_value;
    logic [5:0]  word_index_res;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

### sv/tmn_front.sv
// Front end of the token mutex node: accepts input transactions and
// classifies them into commands. Depends on tmn_pkg.
`default_nettype none

module tmn_front (
  input  tmn_pkg::cfg_t       cfg_i,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [79:0]         s_axis_tdata,  // client_id, req_stamp, word_index, word_value
  input  wire  [2:0]          s_axis_tuser,  // mode
  input  wire                 s_axis_tlast,  // last_word
  input  wire                 full_i,
  output logic                push_o,
  output tmn_pkg::cmd_t       cmd_o
);
  import tmn_pkg::*;

  logic [5:0]  cid;
  logic [31:0] ltime;
  logic [5:0]  widx;
  logic [31:0] wval;
  logic        keep;

  assign cid   = s_axis_tdata[5:0];
  assign ltime = s_axis_tdata[37:6];
  assign widx  = s_axis_tdata[43:38];
  assign wval  = s_axis_tdata[75:44];

  // Dropped events are still taken, so ready follows the queue only
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i && keep;

  // Decode and filter
  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = op_e'(s_axis_tuser);
    keep        = 1'b0;
    unique case (op_e'(s_axis_tuser))
      OP_START, OP_ACQ, OP_REL: begin
        keep = 1'b1;
      end
      OP_REQ: begin
        // unknown or own requester is ignored
        keep        = ({1'b0, cid} < cfg_i.n_eff) && (cid != cfg_i.own_id);
        cmd_o.id    = cid;
        cmd_o.value = ltime;
      end
      OP_WORD: begin
        keep        = 1'b1;
        cmd_o.id    = widx;
        cmd_o.value = wval;
        cmd_o.store = {1'b0, widx} < cfg_i.n_eff;
        cmd_o.last  = s_axis_tlast;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/tmn_queue.sv
// Short command queue between the front and back of the token mutex node.
// Depends on tmn_pkg.
`default_nettype none

module tmn_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  tmn_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           valid_o,
  output tmn_pkg::cmd_t  cmd_o
);
  import tmn_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/tmn_back.sv
// Back end of the token mutex node: executes commands, holds the logical
// clock, request and token time stores and the result register. Uses tmn_pkg.
`default_nettype none
`include "assert_macros.svh"

module tmn_back #(
  parameter int unsigned MAX_CLIENTS = 8
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  tmn_pkg::cfg_t  cfg_i,
  input  wire            cmd_valid_i,
  input  tmn_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  output logic           res_valid_o,
  input  wire            res_ready_i,
  output tmn_pkg::res_t  res_o
);
  import tmn_pkg::*;

  localparam int unsigned IW = $clog2(MAX_CLIENTS);
  localparam int unsigned CW = $clog2(MAX_CLIENTS + 1);

  back_state_e st_q, st_d;
  node_mode_e  mode_q, mode_d;
  logic [31:0] clk_q, clk_d;
  cmd_t        cmd_q, cmd_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [5:0]  dest_q, dest_d;
  logic [6:0]  mod_q, mod_d;
  logic        grant_q, grant_d;

  // Time stores with per-entry valid bits (unwritten entries read zero)
  logic [31:0] req_mem [MAX_CLIENTS];
  logic [31:0] tok_mem [MAX_CLIENTS];
  logic [MAX_CLIENTS-1:0] req_vld_q, tok_vld_q;
  logic [31:0] req_rd_q, tok_rd_q;
  logic        req_rv_q, tok_rv_q;
  logic        req_we, tok_we, clr_all;
  logic [IW-1:0] req_wa, tok_wa;
  logic [31:0] req_wd, tok_wd;

  // Result register
  logic        out_vld_q;
  res_t        out_q;
  logic        out_free, out_load;
  res_t        res_d;

  logic [31:0] req_val, tok_val;
  logic [6:0]  idx_nx7;
  logic [IW-1:0] idx_wrap;
  logic        own_in;

  assign out_free    = !out_vld_q || res_ready_i;
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  assign req_val  = req_rv_q ? req_rd_q : '0;
  assign tok_val  = tok_rv_q ? tok_rd_q : '0;
  assign idx_nx7  = 7'(idx_q) + 7'd1;
  assign idx_wrap = (idx_nx7 == cfg_i.n_eff) ? '0 : idx_nx7[IW-1:0];
  assign own_in   = {1'b0, cfg_i.own_id} < cfg_i.n_eff;

  // Sequencer: next state, store writes and result generation
  always_comb begin
    st_d      = st_q;
    mode_d    = mode_q;
    clk_d     = clk_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    dest_d    = dest_q;
    mod_d     = mod_q;
    grant_d   = grant_q;
    cmd_pop_o = 1'b0;
    req_we    = 1'b0;
    req_wa    = cmd_q.id[IW-1:0];
    req_wd    = cmd_q.value;
    tok_we    = 1'b0;
    tok_wa    = cmd_q.id[IW-1:0];
    tok_wd    = cmd_q.value;
    clr_all   = 1'b0;
    out_load  = 1'b0;
    res_d             = '0;
    res_d.peer_id     = cfg_i.own_id;
    res_d.time_value  = clk_q;

    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          st_d      = S_EXEC;
        end
      end

      S_EXEC: begin
        st_d = S_IDLE;
        unique case (cmd_q.op)
          OP_START: begin
            clr_all = 1'b1;
            mode_d  = cfg_i.starts_with_token ? NM_PRESENT : NM_IDLE;
          end
          OP_REQ: begin
            req_we = 1'b1;
            if (mode_q == NM_PRESENT) begin
              mode_d = NM_IDLE;
              dest_d = cmd_q.id;
              idx_d  = '0;
              st_d   = S_TOK_RD;
            end
          end
          OP_WORD: begin
            tok_we = cmd_q.store;
            if (cmd_q.last) begin
              st_d = S_OWN;
            end
          end
          OP_ACQ: begin
            clk_d = clk_q + 32'd1;
            if (mode_q == NM_PRESENT || mode_q == NM_HELD) begin
              mode_d  = NM_HELD;
              grant_d = 1'b1;
            end else begin
              mode_d  = NM_WAIT;
              grant_d = 1'b0;
            end
            st_d = S_BCAST;
          end
          OP_REL: begin
            if (mode_q == NM_PRESENT || mode_q == NM_HELD) begin
              clk_d = clk_q + 32'd1;
              mod_d = 7'(cfg_i.own_id) + 7'd1;
              st_d  = S_MOD;
            end
          end
          default: begin
            st_d = S_IDLE;
          end
        endcase
      end

      // Start index of the scan: (own_id + 1) mod n by repeated subtraction
      S_MOD: begin
        if (mod_q >= cfg_i.n_eff) begin
          mod_d = mod_q - cfg_i.n_eff;
        end else begin
          idx_d = mod_q[IW-1:0];
          cnt_d = '0;
          st_d  = S_SCAN_RD;
        end
      end

      // Token complete: stamp own entry, grant a waiting lock
      S_OWN: begin
        tok_we = own_in;
        tok_wa = cfg_i.own_id[IW-1:0];
        tok_wd = clk_q;
        st_d   = S_IDLE;
        if (mode_q == NM_WAIT) begin
          mode_d = NM_HELD;
          st_d   = S_GRANT;
        end else if (mode_q != NM_HELD) begin
          mode_d = NM_PRESENT;
        end
      end

      S_BCAST: begin
        if (out_free) begin
          out_load   = 1'b1;
          res_d.kind = K_BCAST;
          res_d.last = !grant_q;
          st_d       = grant_q ? S_GRANT : S_IDLE;
        end
      end

      S_GRANT: begin
        if (out_free) begin
          out_load   = 1'b1;
          res_d.kind = K_GRANT;
          res_d.last = 1'b1;
          st_d       = S_IDLE;
        end
      end

      S_SCAN_RD: begin
        st_d = S_SCAN_CMP;
      end

      // First client with a newer request than its token entry wins
      S_SCAN_CMP: begin
        if ((7'(idx_q) != 7'(cfg_i.own_id)) && (req_val > tok_val)) begin
          mode_d = NM_IDLE;
          dest_d = 6'(idx_q);
          idx_d  = '0;
          st_d   = S_TOK_RD;
        end else if (7'(cnt_q) + 7'd1 == cfg_i.n_eff) begin
          st_d = S_KEEP;
        end else begin
          cnt_d = cnt_q + 1'b1;
          idx_d = idx_wrap;
          st_d  = S_SCAN_RD;
        end
      end

      S_KEEP: begin
        if (out_free) begin
          out_load   = 1'b1;
          mode_d     = NM_PRESENT;
          res_d.kind = K_KEPT;
          res_d.last = 1'b1;
          st_d       = S_IDLE;
        end
      end

      S_TOK_RD: begin
        st_d = S_TOK_OUT;
      end

      // Stream one token word per read
      S_TOK_OUT: begin
        if (out_free) begin
          out_load             = 1'b1;
          res_d.kind           = K_TOKEN;
          res_d.peer_id        = dest_q;
          res_d.time_value     = tok_val;
          res_d.word_index_res = 6'(idx_q);
          res_d.last           = idx_nx7 == cfg_i.n_eff;
          if (idx_nx7 == cfg_i.n_eff) begin
            st_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
            st_d  = S_TOK_RD;
          end
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      mode_q    <= NM_IDLE;
      clk_q     <= '0;
      grant_q   <= 1'b0;
      out_vld_q <= 1'b0;
      req_vld_q <= '0;
      tok_vld_q <= '0;
    end else begin
      st_q    <= st_d;
      mode_q  <= mode_d;
      clk_q   <= clk_d;
      grant_q <= grant_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (clr_all) begin
        req_vld_q <= '0;
        tok_vld_q <= '0;
      end else begin
        if (req_we) begin
          req_vld_q[req_wa] <= 1'b1;
        end
        if (tok_we) begin
          tok_vld_q[tok_wa] <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    dest_q <= dest_d;
    mod_q  <= mod_d;
    if (out_load) begin
      out_q <= res_d;
    end
  end

  // Time stores: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (req_we) begin
      req_mem[req_wa] <= req_wd;
    end
    if (tok_we) begin
      tok_mem[tok_wa] <= tok_wd;
    end
    req_rd_q <= req_mem[idx_q];
    tok_rd_q <= tok_mem[idx_q];
    req_rv_q <= req_vld_q[idx_q];
    tok_rv_q <= tok_vld_q[idx_q];
  end

  // Assertions
  `TMN_ASSERT_NEXT(a_grant_held, out_load && (res_d.kind == K_GRANT), mode_q == NM_HELD, "grant without holding the lock")
  `TMN_ASSERT_NEXT(a_token_gone, out_load && (res_d.kind == K_TOKEN) && res_d.last, mode_q == NM_IDLE, "token sent but still owned")
  `TMN_ASSERT(a_clock_step, (clk_q == $past(clk_q)) || (clk_q == $past(clk_q) + 32'd1), "logical clock jumped")
  `TMN_ASSERT(a_word_range, (st_q == S_TOK_OUT) |-> (7'(idx_q) < cfg_i.n_eff), "token word index out of range")

endmodule

`default_nettype wire

### sv/token_mutex_node.sv
// Token mutex node top level. Sequencer in tmn_back: an acquire broadcasts and may grant, a
// final token word may grant, a token is sent one word per read, and a release finds the
// start index, then scans clients in turn and keeps the token if none waits. Output
// stalls hold the sequencer until the result register is free.
// Reset: config to own_id 0, 8 clients, no token; time stores read zero via valid bits.
`default_nettype none

module token_mutex_node #(
  parameter int unsigned MAX_CLIENTS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [6:0]  cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [79:0] s_axis_tdata,  // client_id, req_stamp, word_index, word_value
  input  wire  [2:0]  s_axis_tuser,  // mode
  input  wire         s_axis_tlast,  // last_word
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,  // peer_id, time_value, word_index_res
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast   // last
);
  import tmn_pkg::*;

  localparam logic [6:0] MaxN = 7'(MAX_CLIENTS);

  logic [5:0] own_q;
  logic [6:0] count_q;
  logic       swt_q;
  cfg_t       cfg;
  logic       push, full, pop, q_valid;
  cmd_t       f_cmd, q_cmd;
  res_t       res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q   <= '0;
      count_q <= 7'd8;
      swt_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OWN_ID:       own_q   <= cfg_data_i[5:0];
        CFG_CLIENT_COUNT: count_q <= cfg_data_i;
        CFG_STARTS_TOKEN: swt_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Client count saturated to the supported range
  always_comb begin
    cfg.own_id            = own_q;
    cfg.starts_with_token = swt_q;
    if (count_q < 7'd2) begin
      cfg.n_eff = 7'd2;
    end else if (count_q > MaxN) begin
      cfg.n_eff = MaxN;
    end else begin
      cfg.n_eff = count_q;
    end
  end

  tmn_front u_front (
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (f_cmd)
  );

  tmn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  tmn_back #(
    .MAX_CLIENTS (MAX_CLIENTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.word_index_res, res.time_value, res.peer_id};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

### verif/token_mutex_node_test.sv
// Self-checking testbench for token_mutex_node: directed and random event streams
// with a scoreboard class that predicts every result transaction.
// Depends on tmn_pkg and token_mutex_node only.
`default_nettype none

module token_mutex_node_test;
  import tmn_pkg::*;

  localparam int unsigned MaxClients = 8;
  localparam int unsigned ClkHalf    = 6;
  localparam int unsigned HoldOff    = 200;      // covers the slowest silent event
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandPerPhase = 55;
  localparam int unsigned Phases     = 6;

  // Mode codes the block must ignore
  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  // One input event as the block sees it
  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  client_id;
    logic [31:0] req_stamp;
    logic [5:0]  word_index;
    logic [31:0] word_value;
    logic        last_word;
  } node_event_t;

  // Predicts the result transactions of each accepted event and checks the outputs
  class mutex_scoreboard;
    bit [5:0]   own_id;
    bit [6:0]   client_count;
    bit         starts_tok;
    node_mode_e holder;
    bit [31:0]  lamport;
    bit [31:0]  req_time [MaxClients];
    bit [31:0]  grant_time [MaxClients];
    res_t       due [$];
    int         fails;

    function new();
      own_id       = '0;
      client_count = 7'd8;
      starts_tok   = 1'b0;
      holder       = NM_IDLE;
      lamport      = '0;
      foreach (req_time[i]) req_time[i] = '0;
      foreach (grant_time[i]) grant_time[i] = '0;
      fails        = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] data);
      case (idx)
        CFG_OWN_ID:       own_id = data[5:0];
        CFG_CLIENT_COUNT: client_count = data;
        CFG_STARTS_TOKEN: starts_tok = data[0];
        default: ;
      endcase
    endfunction

    // Client count saturated to what the node supports
    function int unsigned clients();
      if (client_count < 2) return 2;
      if (client_count > MaxClients) return MaxClients;
      return client_count;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void emit(kind_e k, bit [5:0] peer, bit [31:0] tv, bit [5:0] idx, bit last);
      res_t r;
      r.kind           = k;
      r.peer_id        = peer;
      r.time_value     = tv;
      r.word_index_res = idx;
      r.last           = last;
      due.push_back(r);
    endfunction

    function void stream_token(bit [5:0] dest, int unsigned n);
      for (int unsigned i = 0; i < n; i++)
        emit(K_TOKEN, dest, grant_time[i], i[5:0], (i + 1 == n));
    endfunction

    function void note_event(node_event_t ev);
      int unsigned n;
      int unsigned i;
      bit found;
      n = clients();
      found = 1'b0;
      case (ev.mode)
        OP_START: begin
          foreach (req_time[j]) req_time[j] = '0;
          foreach (grant_time[j]) grant_time[j] = '0;
          holder = starts_tok ? NM_PRESENT : NM_IDLE;
        end
        OP_REQ: begin
          if (ev.client_id < n && ev.client_id != own_id) begin
            req_time[ev.client_id] = ev.req_stamp;
            // idle holder passes the token straight on
            if (holder == NM_PRESENT) begin
              holder = NM_IDLE;
              stream_token(ev.client_id, n);
            end
          end
        end
        OP_WORD: begin
          if (ev.word_index < n) grant_time[ev.word_index] = ev.word_value;
          if (ev.last_word) begin
            if (own_id < n) grant_time[own_id] = lamport;
            if (holder == NM_WAIT) begin
              holder = NM_HELD;
              emit(K_GRANT, own_id, lamport, '0, 1'b1);
            end else if (holder != NM_HELD) begin
              holder = NM_PRESENT;
            end
          end
        end
        OP_ACQ: begin
          lamport++;
          if (holder == NM_PRESENT || holder == NM_HELD) begin
            holder = NM_HELD;
            emit(K_BCAST, own_id, lamport, '0, 1'b0);
            emit(K_GRANT, own_id, lamport, '0, 1'b1);
          end else begin
            holder = NM_WAIT;
            emit(K_BCAST, own_id, lamport, '0, 1'b1);
          end
        end
        OP_REL: begin
          if (holder == NM_PRESENT || holder == NM_HELD) begin
            lamport++;
            // round-robin scan from the client after this one
            for (int unsigned k = 1; k <= n && !found; k++) begin
              i = (own_id + k) % n;
              if (i != own_id && req_time[i] > grant_time[i]) begin
                found  = 1'b1;
                holder = NM_IDLE;
                stream_token(i[5:0], n);
              end
            end
            if (!found) begin
              holder = NM_PRESENT;
              emit(K_KEPT, own_id, lamport, '0, 1'b1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // One line per mismatch, each one counted
    task report_mismatch(string msg);
      fails++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [1:0] kind, logic [47:0] data, logic last);
      res_t exp;
      if (due.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d data %h", kind, data));
        return;
      end
      exp = due.pop_front();
      if (kind !== exp.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", kind, exp.kind));
      if (data[5:0] !== exp.peer_id)
        report_mismatch($sformatf("peer_id %0d, expected %0d", data[5:0], exp.peer_id));
      if (data[37:6] !== exp.time_value)
        report_mismatch($sformatf("time_value %h, expected %h", data[37:6], exp.time_value));
      if (data[43:38] !== exp.word_index_res)
        report_mismatch($sformatf("word_index_res %0d, expected %0d", data[43:38],
                                  exp.word_index_res));
      if (last !== exp.last)
        report_mismatch($sformatf("last %b, expected %b", last, exp.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [6:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;  // client_id, req_stamp, word_index, word_value
  logic [2:0]  s_axis_tuser;  // mode
  logic        s_axis_tlast;  // last_word
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;  // peer_id, time_value, word_index_res
  logic [1:0]  m_axis_tuser;  // kind
  logic        m_axis_tlast;  // last

  mutex_scoreboard board;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     cycles = 0;

  token_mutex_node #(.MAX_CLIENTS(MaxClients)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Clock
  always #(ClkHalf) clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("token_mutex_node_test: FAIL");
      $finish;
    end
  end

  // Receiver with random back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // Drive one event and wait for its transaction
  task automatic post(logic [2:0] mode, logic [5:0] cid, logic [31:0] ltime,
                      logic [5:0] widx, logic [31:0] wval, logic wlast);
    node_event_t ev;
    ev = '{mode, cid, ltime, widx, wval, wlast};
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0, wval, widx, ltime, cid};
    s_axis_tlast  <= wlast;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_event(ev);
    @(negedge clk_i);
  endtask

  // Event whose unused fields carry random values
  task automatic post_plain(logic [2:0] mode);
    post(mode, 6'($urandom_range(63)), $urandom, 6'($urandom_range(63)), $urandom,
         1'($urandom_range(1)));
  endtask

  // Hold the input idle until every expected result has been seen
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (board.pending() != 0);
  endtask

  // Write all three registers on consecutive cycles
  task automatic program_node(logic [5:0] own, logic [6:0] cnt, logic tok);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_OWN_ID; cfg_data_i <= {1'b0, own};
    board.set_reg(CFG_OWN_ID, {1'b0, own});
    @(negedge clk_i);
    cfg_idx_i <= CFG_CLIENT_COUNT; cfg_data_i <= cnt;
    board.set_reg(CFG_CLIENT_COUNT, cnt);
    @(negedge clk_i);
    cfg_idx_i <= CFG_STARTS_TOKEN; cfg_data_i <= {6'b0, tok};
    board.set_reg(CFG_STARTS_TOKEN, {6'b0, tok});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_events();
    post_plain(OP_START);
    post_plain(OP_ACQ);                                     // token present: immediate grant
    post_plain(OP_ACQ);                                     // acquire while holding
    post(OP_WORD, '0, '0, 6'd2, 32'h8000_0000, 1'b1);       // token completes while holding
    post_plain(OP_REL);                                     // nobody waiting: token kept
    post(OP_REQ, 6'd0, 32'hFFFF_FFFF, '0, '0, 1'b0);        // request from own id
    post(OP_REQ, 6'd63, 32'hFFFF_FFFF, '0, '0, 1'b0);       // requester beyond count
    post(OP_REQ, 6'd3, 32'hFFFF_FFFF, '0, '0, 1'b0);        // idle holder forwards token
    post_plain(OP_REL);                                     // release without token
    post_plain(OP_ACQ);                                     // now waiting
    post_plain(OP_ACQ);                                     // acquire while waiting
    post(OP_WORD, '0, '0, 6'd0, 32'h0, 1'b0);
    post(OP_WORD, '0, '0, 6'd63, 32'hFFFF_FFFF, 1'b0);      // index out of range
    post(OP_WORD, '0, '0, 6'd7, 32'h7FFF_FFFF, 1'b1);       // arrival closes the wait
    post(OP_REQ, 6'd5, 32'h8000_0000, '0, '0, 1'b0);        // recorded only
    post(OP_REQ, 6'd7, 32'h7FFF_FFFF, '0, '0, 1'b0);        // equal time, not newer
    post_plain(OpUnusedLo);
    post_plain(OpUnusedHi);
    post_plain(OP_REL);                                     // scan hands token on
    post(OP_WORD, '0, '0, 6'd1, 32'h5, 1'b1);               // token arrives unasked
    post_plain(OP_REL);                                     // release from present
    post(OP_REQ, 6'd1, 32'h0, '0, '0, 1'b0);
    post_plain(OP_START);
    post(OP_REQ, 6'd7, 32'h1, '0, '0, 1'b0);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(3))
      0:       return 32'hFFFF_FFFF;
      1:       return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Random events: mostly lock traffic and complete tokens, some noise
  task automatic random_events(int target);
    int items;
    int pick;
    int n_now;
    int cut;
    bit paused;
    logic [5:0] idx;
    items  = 0;
    paused = 1'b0;
    while (items < target) begin
      if (!paused && items >= target / 2) begin
        drain();
        paused = 1'b1;
      end
      pick  = $urandom_range(99);
      n_now = board.clients();
      if (pick < 20) begin
        post_plain(OP_ACQ);
        items++;
      end else if (pick < 40) begin
        post_plain(OP_REL);
        items++;
      end else if (pick < 60) begin
        idx = 6'(($urandom_range(4) != 0) ? $urandom_range(n_now - 1) : $urandom_range(63));
        post(OP_REQ, idx, pick_time(), 6'($urandom_range(63)), $urandom,
             1'($urandom_range(1)));
        items++;
      end else if (pick < 80) begin
        // whole token, now and then cut short or with a stray index
        cut = ($urandom_range(9) == 0) ? $urandom_range(n_now - 1) : n_now - 1;
        for (int w = 0; w <= cut; w++) begin
          idx = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : w[5:0];
          post(OP_WORD, 6'($urandom_range(63)), $urandom, idx, pick_time(), (w == cut));
        end
        items += cut + 1;
      end else if (pick < 90) begin
        post(OP_WORD, 6'($urandom_range(63)), $urandom, 6'($urandom_range(63)), pick_time(),
             1'($urandom_range(1)));
        items++;
      end else if (pick < 96) begin
        post_plain(OP_START);
        items++;
      end else begin
        post_plain(3'($urandom_range(OpUnusedLo, OpUnusedHi)));
      end
    end
  endtask

  // Per-phase settings: own id, client count, token at start
  logic [5:0] own_tbl [Phases] = '{6'd0, 6'd7, 6'd63, 6'd3, 6'd1, 6'd5};
  logic [6:0] cnt_tbl [Phases] = '{7'd8, 7'd64, 7'd2, 7'd5, 7'd9, 7'd7};
  logic       tok_tbl [Phases] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  // Main sequence
  initial begin
    board          = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    s_axis_tlast   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < Phases; p++) begin
      if (p != 0) begin
        drain();
        repeat (HoldOff) @(negedge clk_i);
      end
      program_node(own_tbl[p], cnt_tbl[p], tok_tbl[p]);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (p == 0) directed_events();
      else post_plain(OP_START);
      random_events(RandPerPhase);
    end

    drain();
    repeat (HoldOff) @(negedge clk_i);
    if (board.fails == 0) $display("token_mutex_node_test: PASS");
    else $display("token_mutex_node_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
